// File: rtl/sfm_pkg.sv
// Shared constants, types and state codes for the stereo FIR block.
package sfm_pkg;

    localparam int TAPS_DEFAULT       = 256;
    localparam int COEF_WIDTH_DEFAULT = 16;
    localparam int SAMPLE_W           = 16;
    localparam int TAP_W              = 8;
    localparam int ACC_W              = 40;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_COEF   = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } mac_ctrl_t;

endpackage

// File: rtl/sfm_in_if.sv
// Input channel: sample items and coefficient write items.
interface sfm_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 mode;
    logic signed [sfm_pkg::SAMPLE_W-1:0]  sample;
    logic        [sfm_pkg::TAP_W-1:0]     tap;
    logic signed [sfm_pkg::SAMPLE_W-1:0]  left_coef;
    logic signed [sfm_pkg::SAMPLE_W-1:0]  right_coef;

    modport source (output valid, mode, sample, tap, left_coef, right_coef, input ready);
    modport sink   (input valid, mode, sample, tap, left_coef, right_coef, output ready);
endinterface

// File: rtl/sfm_out_if.sv
// Output channel: left and right convolution sums.
interface sfm_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [sfm_pkg::ACC_W-1:0]  left_out;
    logic signed [sfm_pkg::ACC_W-1:0]  right_out;

    modport source (output valid, left_out, right_out, input ready);
    modport sink   (input valid, left_out, right_out, output ready);
endinterface

// File: rtl/sfm_mac.sv
// Dual multiply-accumulate datapath: one left and one right product per cycle.
module sfm_mac #(
    parameter int COEF_WIDTH = sfm_pkg::COEF_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sfm_pkg::mac_ctrl_t                  ctrl,
    input  logic signed [sfm_pkg::SAMPLE_W-1:0] x,
    input  logic signed [COEF_WIDTH-1:0]        lc,
    input  logic signed [COEF_WIDTH-1:0]        rc,
    output logic signed [sfm_pkg::ACC_W-1:0]    acc_l,
    output logic signed [sfm_pkg::ACC_W-1:0]    acc_r,
    output logic                                done
);

    localparam int PROD_W = sfm_pkg::SAMPLE_W + COEF_WIDTH;

    sfm_pkg::mac_ctrl_t               ctrl_reg;
    logic signed [PROD_W-1:0]         prod_l_reg, prod_r_reg;
    logic signed [PROD_W-1:0]         prod_l_next, prod_r_next;
    logic signed [sfm_pkg::ACC_W-1:0] acc_l_reg, acc_r_reg;
    logic signed [sfm_pkg::ACC_W-1:0] acc_l_next, acc_r_next;
    logic signed [sfm_pkg::ACC_W-1:0] base_l, base_r;
    logic                             done_reg;

    assign prod_l_next = x * lc;
    assign prod_r_next = x * rc;

    assign base_l     = ctrl_reg.first ? '0 : acc_l_reg;
    assign base_r     = ctrl_reg.first ? '0 : acc_r_reg;
    assign acc_l_next = base_l + sfm_pkg::ACC_W'(prod_l_reg);
    assign acc_r_next = base_r + sfm_pkg::ACC_W'(prod_r_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctrl_reg <= ctrl;
            done_reg <= ctrl_reg.vld & ctrl_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_l_reg <= prod_l_next;
        prod_r_reg <= prod_r_next;
        if (ctrl_reg.vld)
        begin
            acc_l_reg <= acc_l_next;
            acc_r_reg <= acc_r_next;
        end
    end

    assign acc_l = acc_l_reg;
    assign acc_r = acc_r_reg;
    assign done  = done_reg;

endmodule

// File: rtl/stereo_fir_from_mono.sv
// Stereo FIR top level: sample ring, coefficient store, sequencer and output register.
// Each sample item is written into a ring of TAPS past samples and then convolved with
// the left and right impulse responses, one dual multiply-accumulate per tap, reading
// one sample and one coefficient pair per cycle from two memories. A sample item is
// accepted only while idle, and no new item is taken until the tap loop is through and
// its result is in the output register, where a finished result waits. A coefficient
// item is written while idle and gives no result. After reset a clearing pass over all
// TAPS addresses zeroes both memories before the first item is accepted.
module stereo_fir_from_mono #(
    parameter int TAPS       = sfm_pkg::TAPS_DEFAULT,
    parameter int COEF_WIDTH = sfm_pkg::COEF_WIDTH_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    sfm_in_if.sink    din,
    sfm_out_if.source dout
);

    localparam int AW = $clog2(TAPS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TAPS - 1);

    logic signed [sfm_pkg::SAMPLE_W-1:0] ring_mem [TAPS];
    logic        [2*COEF_WIDTH-1:0]      coef_mem [TAPS];

    sfm_pkg::state_t     state_reg, state_next;
    logic [AW-1:0]       cnt_reg, cnt_next;
    logic [AW-1:0]       wp_reg, wp_next;
    logic [AW-1:0]       rp_reg, rp_next;
    logic                fin_reg, fin_next;
    logic                out_vld_reg, out_vld_next;
    sfm_pkg::mac_ctrl_t  ctrl_rd_reg, ctrl_issue;

    logic signed [sfm_pkg::SAMPLE_W-1:0] smp_rd_reg;
    logic        [2*COEF_WIDTH-1:0]      coef_rd_reg;
    logic signed [sfm_pkg::ACC_W-1:0]    left_out_reg, right_out_reg;

    logic                                ring_we, coef_we;
    logic [AW-1:0]                       ring_waddr, coef_waddr;
    logic signed [sfm_pkg::SAMPLE_W-1:0] ring_wdata;
    logic [2*COEF_WIDTH-1:0]             coef_wdata;

    logic                                accept, tap_ok, out_free, load_out;
    logic signed [31:0]                  lc32, rc32;
    logic signed [sfm_pkg::ACC_W-1:0]    acc_l, acc_r;
    logic                                mac_done;

    assign accept   = din.valid & din.ready;
    assign out_free = ~out_vld_reg | dout.ready;
    assign tap_ok   = 32'(din.tap) < 32'(TAPS);
    assign lc32     = 32'(din.left_coef);
    assign rc32     = 32'(din.right_coef);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sfm_pkg::ST_CLEAR:
            begin
                if (cnt_reg == LAST_ADDR)
                    state_next = sfm_pkg::ST_IDLE;
            end
            sfm_pkg::ST_IDLE:
            begin
                if (accept && din.mode == sfm_pkg::MODE_SAMPLE)
                    state_next = sfm_pkg::ST_RUN;
            end
            sfm_pkg::ST_RUN:
            begin
                if (cnt_reg == LAST_ADDR)
                    state_next = sfm_pkg::ST_DRAIN;
            end
            sfm_pkg::ST_DRAIN:
            begin
                if (fin_reg && out_free)
                    state_next = sfm_pkg::ST_IDLE;
            end
            default:
                state_next = sfm_pkg::ST_CLEAR;
        endcase
    end

    always_comb
    begin
        din.ready  = 1'b0;
        ring_we    = 1'b0;
        coef_we    = 1'b0;
        ring_waddr = wp_reg;
        coef_waddr = AW'(din.tap);
        ring_wdata = din.sample;
        coef_wdata = {lc32[COEF_WIDTH-1:0], rc32[COEF_WIDTH-1:0]};
        ctrl_issue = '0;
        load_out   = 1'b0;
        cnt_next   = cnt_reg;
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        case (state_reg)
            sfm_pkg::ST_CLEAR:
            begin
                ring_we    = 1'b1;
                coef_we    = 1'b1;
                ring_waddr = cnt_reg;
                coef_waddr = cnt_reg;
                ring_wdata = '0;
                coef_wdata = '0;
                cnt_next   = (cnt_reg == LAST_ADDR) ? '0 : cnt_reg + 1'b1;
            end
            sfm_pkg::ST_IDLE:
            begin
                din.ready = 1'b1;
                if (accept)
                begin
                    if (din.mode == sfm_pkg::MODE_SAMPLE)
                    begin
                        ring_we  = 1'b1;
                        rp_next  = wp_reg;
                        cnt_next = '0;
                        wp_next  = (wp_reg == LAST_ADDR) ? '0 : wp_reg + 1'b1;
                    end
                    else
                    begin
                        coef_we = tap_ok;
                    end
                end
            end
            sfm_pkg::ST_RUN:
            begin
                ctrl_issue.vld   = 1'b1;
                ctrl_issue.first = (cnt_reg == '0);
                ctrl_issue.last  = (cnt_reg == LAST_ADDR);
                cnt_next = (cnt_reg == LAST_ADDR) ? '0 : cnt_reg + 1'b1;
                rp_next  = (rp_reg == '0) ? LAST_ADDR : rp_reg - 1'b1;
            end
            sfm_pkg::ST_DRAIN:
            begin
                load_out = fin_reg & out_free;
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        fin_next = fin_reg;
        if (load_out)
            fin_next = 1'b0;
        else if (mac_done)
            fin_next = 1'b1;
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (load_out)
            out_vld_next = 1'b1;
        else if (dout.ready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sfm_pkg::ST_CLEAR;
            cnt_reg     <= '0;
            wp_reg      <= '0;
            rp_reg      <= '0;
            fin_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
            ctrl_rd_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            wp_reg      <= wp_next;
            rp_reg      <= rp_next;
            fin_reg     <= fin_next;
            out_vld_reg <= out_vld_next;
            ctrl_rd_reg <= ctrl_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_mem[ring_waddr] <= ring_wdata;
        smp_rd_reg <= ring_mem[rp_reg];
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
            coef_mem[coef_waddr] <= coef_wdata;
        coef_rd_reg <= coef_mem[cnt_reg];
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            left_out_reg  <= acc_l;
            right_out_reg <= acc_r;
        end
    end

    sfm_mac #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl_rd_reg),
        .x     (smp_rd_reg),
        .lc    (signed'(coef_rd_reg[2*COEF_WIDTH-1:COEF_WIDTH])),
        .rc    (signed'(coef_rd_reg[COEF_WIDTH-1:0])),
        .acc_l (acc_l),
        .acc_r (acc_r),
        .done  (mac_done)
    );

    assign dout.valid     = out_vld_reg;
    assign dout.left_out  = left_out_reg;
    assign dout.right_out = right_out_reg;

endmodule

// File: sim/tb_stereo_fir_from_mono.sv
// Self-checking testbench for the stereo FIR block: random and directed items, result scoreboard.
module tb_stereo_fir_from_mono;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS      = 1100;
    localparam int CALM_ITEMS = 120;
    localparam int HOLD_LEN   = 3000;
    localparam int LIMIT      = 1_500_000;

    typedef struct packed {
        logic signed [sfm_pkg::ACC_W-1:0] left_sum;
        logic signed [sfm_pkg::ACC_W-1:0] right_sum;
    } sums_t;

    class stereo_sum_tracker;
        logic signed [sfm_pkg::SAMPLE_W-1:0] ring [sfm_pkg::TAPS_DEFAULT];
        logic signed [sfm_pkg::SAMPLE_W-1:0] left_taps [sfm_pkg::TAPS_DEFAULT];
        logic signed [sfm_pkg::SAMPLE_W-1:0] right_taps [sfm_pkg::TAPS_DEFAULT];
        int unsigned                         newest_slot;
        sums_t                               expected_sums [$];
        int                                  mismatches;
        int                                  checked;

        function new();
            for (int i = 0; i < sfm_pkg::TAPS_DEFAULT; i++)
            begin
                ring[i]       = '0;
                left_taps[i]  = '0;
                right_taps[i] = '0;
            end
            newest_slot = 0;
            mismatches  = 0;
            checked     = 0;
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        function void take_item(logic mode, logic signed [sfm_pkg::SAMPLE_W-1:0] smp,
                                logic [sfm_pkg::TAP_W-1:0] tap,
                                logic signed [sfm_pkg::SAMPLE_W-1:0] lc,
                                logic signed [sfm_pkg::SAMPLE_W-1:0] rc);
            longint      acc_l;
            longint      acc_r;
            int unsigned idx;
            sums_t       e;
            if (mode == sfm_pkg::MODE_COEF)
            begin
                if (int'(tap) < sfm_pkg::TAPS_DEFAULT)
                begin
                    left_taps[tap]  = lc;
                    right_taps[tap] = rc;
                end
                return;
            end
            ring[newest_slot] = smp;
            newest_slot = (newest_slot + 1) % sfm_pkg::TAPS_DEFAULT;
            acc_l = 0;
            acc_r = 0;
            idx = newest_slot;
            for (int i = 0; i < sfm_pkg::TAPS_DEFAULT; i++)
            begin
                idx = (idx == 0) ? sfm_pkg::TAPS_DEFAULT - 1 : idx - 1;
                acc_l += longint'(ring[idx]) * longint'(left_taps[i]);
                acc_r += longint'(ring[idx]) * longint'(right_taps[i]);
            end
            e.left_sum  = acc_l[sfm_pkg::ACC_W-1:0];
            e.right_sum = acc_r[sfm_pkg::ACC_W-1:0];
            expected_sums.push_back(e);
        endfunction

        task check_sums(logic signed [sfm_pkg::ACC_W-1:0] l,
                        logic signed [sfm_pkg::ACC_W-1:0] r);
            sums_t e;
            checked++;
            if (expected_sums.size() == 0)
            begin
                report($sformatf("unexpected result left=%0d right=%0d", l, r));
                return;
            end
            e = expected_sums.pop_front();
            if (l !== e.left_sum)
                report($sformatf("result %0d left_out got %0d want %0d", checked, l, e.left_sum));
            if (r !== e.right_sum)
                report($sformatf("result %0d right_out got %0d want %0d", checked, r,
                                 e.right_sum));
        endtask
    endclass

    logic clk;
    logic rst_n;

    sfm_in_if  in_ch ();
    sfm_out_if out_ch ();

    stereo_fir_from_mono dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (in_ch),
        .dout  (out_ch)
    );

    stereo_sum_tracker tracker = new();

    int items_sent = 0;
    bit bursts_on  = 1'b1;
    bit calm       = 1'b0;
    int cycles     = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [sfm_pkg::SAMPLE_W-1:0] pick16();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(logic mode, logic [sfm_pkg::SAMPLE_W-1:0] smp,
                             logic [sfm_pkg::TAP_W-1:0] tap,
                             logic [sfm_pkg::SAMPLE_W-1:0] lc,
                             logic [sfm_pkg::SAMPLE_W-1:0] rc);
        int gap;
        gap = 0;
        if (!calm && bursts_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 3);
        if (gap > 0)
        begin
            @(negedge clk);
            in_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid      = 1'b1;
        in_ch.mode       = mode;
        in_ch.sample     = smp;
        in_ch.tap        = tap;
        in_ch.left_coef  = lc;
        in_ch.right_coef = rc;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        tracker.take_item(mode, smp, tap, lc, rc);
        items_sent++;
        if (items_sent >= ITEMS - CALM_ITEMS)
            calm = 1'b1;
    endtask

    // Result side: random stalls, one long hold-off to back the block up.
    initial
    begin
        int stall_left;
        int hold_left;
        bit hold_done;
        stall_left   = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!hold_done && tracker.checked >= 30)
            begin
                hold_left = HOLD_LEN;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready = 1'b0;
            end
            else if (!calm && bursts_on && $urandom_range(0, 4) == 0)
            begin
                stall_left   = $urandom_range(1, 3) - 1;
                out_ch.ready = 1'b0;
            end
            else
                out_ch.ready = 1'b1;
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                tracker.check_sums(out_ch.left_out, out_ch.right_out);
        end
    end

    initial
    begin
        int n;
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.mode       = sfm_pkg::MODE_SAMPLE;
        in_ch.sample     = '0;
        in_ch.tap        = '0;
        in_ch.left_coef  = '0;
        in_ch.right_coef = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        send_item(sfm_pkg::MODE_SAMPLE, 16'h7FFF, 8'hA5,  16'h1234, 16'h8765);
        send_item(sfm_pkg::MODE_COEF,   16'hFFFF, 8'd0,   16'h7FFF, 16'h8000);
        send_item(sfm_pkg::MODE_COEF,   16'h8000, 8'd255, 16'h8000, 16'h7FFF);
        send_item(sfm_pkg::MODE_COEF,   16'h0000, 8'd1,   16'hFFFF, 16'h0001);
        send_item(sfm_pkg::MODE_SAMPLE, 16'h8000, 8'hFF,  16'hFFFF, 16'hFFFF);
        send_item(sfm_pkg::MODE_SAMPLE, 16'h7FFF, 8'h00,  16'h0000, 16'h0000);
        send_item(sfm_pkg::MODE_SAMPLE, 16'h0000, 8'h5A,  16'h7FFF, 16'h8000);
        send_item(sfm_pkg::MODE_SAMPLE, 16'hFFFF, 8'h01,  16'h8000, 16'h7FFF);
        send_item(sfm_pkg::MODE_COEF,   16'h7FFF, 8'd0,   16'h0000, 16'h4000);
        send_item(sfm_pkg::MODE_COEF,   16'h1111, 8'd128, 16'hC000, 16'h3FFF);
        send_item(sfm_pkg::MODE_SAMPLE, 16'h0001, 8'h80,  16'h0000, 16'h0000);
        send_item(sfm_pkg::MODE_SAMPLE, 16'h8000, 8'h7F,  16'h5555, 16'hAAAA);

        // Full-scale taps against full-scale samples: largest sums of both signs.
        bursts_on = 1'b1;
        for (int t = 0; t < sfm_pkg::TAPS_DEFAULT; t++)
            send_item(sfm_pkg::MODE_COEF, 16'($urandom), t[sfm_pkg::TAP_W-1:0],
                      16'h8000, 16'h7FFF);
        for (int k = 0; k < sfm_pkg::TAPS_DEFAULT + 4; k++)
            send_item(sfm_pkg::MODE_SAMPLE, (k % 64 == 63) ? 16'h7FFF : 16'h8000,
                      8'($urandom), 16'($urandom), 16'($urandom));

        while (items_sent < ITEMS)
        begin
            bursts_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1) == 0)
            begin
                n = $urandom_range(1, 16);
                repeat (n)
                    send_item(sfm_pkg::MODE_COEF, 16'($urandom), 8'($urandom),
                              pick16(), pick16());
            end
            else
            begin
                n = $urandom_range(1, 12);
                repeat (n)
                    send_item(sfm_pkg::MODE_SAMPLE, pick16(), 8'($urandom),
                              16'($urandom), 16'($urandom));
            end
        end

        @(negedge clk);
        in_ch.valid = 1'b0;
        while (tracker.expected_sums.size() != 0)
            @(posedge clk);
        repeat (sfm_pkg::TAPS_DEFAULT + 8) @(posedge clk);
        if (tracker.expected_sums.size() != 0)
            tracker.report($sformatf("%0d results never arrived",
                                     tracker.expected_sums.size()));
        if (tracker.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
